// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/snft_pkg.sv
// Package for the spectral noise floor tracker: payload types, fixed-point
// constants and the default parameters. Depends on nothing.
package snft_pkg;
  localparam int unsigned BinsDef       = 256;
  localparam int unsigned RisePeriodDef = 8;
  localparam int unsigned WarmupDef     = 20;

  localparam logic [17:0] PostOffset = 18'd91750;
  localparam logic [15:0] PostSlope  = 16'd22938;
  localparam logic [15:0] PostThresh = 16'd11469;
  localparam logic [17:0] MinOffset  = 18'd104858;
  localparam logic [15:0] MinSlope   = 16'd19661;
  localparam logic [16:0] AlphaHigh  = 17'd65208;
  localparam logic [16:0] AlphaLow   = 17'd60293;
  localparam logic [16:0] AlphaBase  = 17'd58982;
  localparam logic [12:0] AlphaGain  = 13'd6423;
  localparam logic [16:0] RiseGain   = 17'd73826;
  localparam logic [15:0] SpeechOne  = 16'd32768;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  bin;
    logic [31:0] power;
  } req_t;

  typedef struct packed {
    logic [31:0] noise;
    logic [15:0] presence;
  } rsp_t;
endpackage

// File: src/snft_div.sv
// Restoring divider: quotient of (num << 16) / den, one quotient bit a cycle.
// Depends on nothing; standalone.
module snft_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [47:0] quot_o
);
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], num_q[47]};
    if (start_i) begin
      num_d  = {num_i, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit into the remainder, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = num_d;
endmodule

// File: src/spectral_noise_floor_tracker.sv
// Spectral noise floor tracker: per-bin noise and minimum stores in RAM.
// Update: the request passes through S_READ, S_DEC, S_DIV, S_SPCH, S_ALPH, S_MUL and S_WB; the
// warm-up, zero-estimate or out-of-range path goes S_READ, S_DEC, S_WB; next request taken once the result leaves.
// Tick: handled in S_IDLE, or through S_RRD and S_RWR when the minimum rise sweeps every bin.
// Reset: a clearing pass zeroes both memories; requests and
// configuration writes wait for it and for any request in flight.
module spectral_noise_floor_tracker #(
  parameter int unsigned BINS          = snft_pkg::BinsDef,
  parameter int unsigned RISE_PERIOD   = snft_pkg::RisePeriodDef,
  parameter int unsigned WARMUP_FRAMES = snft_pkg::WarmupDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  snft_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output snft_pkg::rsp_t out_data_o
);
  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW = $clog2(BINS + 1);
  localparam int FW = $clog2(WARMUP_FRAMES + 1);
  localparam int RW = $clog2(RISE_PERIOD);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_READ  = 11'b00000000100,
    S_DEC   = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_SPCH  = 11'b00000100000,
    S_ALPH  = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_WB    = 11'b00100000000,
    S_RRD   = 11'b01000000000,
    S_RWR   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] noise_mem [BINS];
  logic [31:0] min_mem   [BINS];
  logic [31:0] n_rd_q, m_rd_q;
  logic        mode_q;
  logic [FW-1:0] frames_q;
  logic [RW-1:0] phase_q;
  logic [CW-1:0] idx_q;
  logic [AW-1:0] addr_q;
  logic [31:0] pow_q, noise_q, minv_q;
  logic [15:0] spch_q;
  logic [16:0] alpha_q;
  logic [47:0] ratio_q;
  logic [49:0] acc_q;
  logic        bad_q, warm_q;
  logic        ov_q;
  snft_pkg::rsp_t out_q;

  logic        n_we, m_we;
  logic [AW-1:0] wa, ra;
  logic [31:0] n_wd, m_wd;
  logic        div_start, div_done;
  logic [47:0] div_q;
  logic [31:0] div_den;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  wire acc_in = in_valid_i && !in_stall_o;
  wire warmed = (frames_q == FW'(WARMUP_FRAMES));

  // speech from ratio, clamped; mult is 31x16 bits
  logic [17:0] offs;
  logic [15:0] slope;
  logic [47:0] diff;
  logic [63:0] sprod;
  logic [46:0] sshift;
  logic [15:0] spch_c;
  always_comb begin
    offs   = mode_q ? snft_pkg::MinOffset : snft_pkg::PostOffset;
    slope  = mode_q ? snft_pkg::MinSlope  : snft_pkg::PostSlope;
    diff   = ratio_q - 48'(offs);
    sprod  = 64'(diff[30:0]) * 64'(slope);
    sshift = 47'(sprod >> 17);
    if (ratio_q <= 48'(offs)) spch_c = '0;
    else if (diff[47:31] != '0 || sshift > 47'(snft_pkg::SpeechOne))
      spch_c = snft_pkg::SpeechOne;
    else spch_c = sshift[15:0];
  end

  // alpha
  logic [28:0] aprod;
  logic [16:0] alpha_c;
  always_comb begin
    aprod = 29'(snft_pkg::AlphaGain) * 29'(spch_q) + 29'd16384;
    if (mode_q) alpha_c = snft_pkg::AlphaBase + 17'(aprod >> 15);
    else alpha_c = (spch_q >= snft_pkg::PostThresh) ? snft_pkg::AlphaHigh
                                                   : snft_pkg::AlphaLow;
  end

  // rise multiply
  logic [48:0] rprod;
  logic [32:0] rval;
  logic [31:0] rsat;
  always_comb begin
    rprod = 49'(m_rd_q) * 49'(snft_pkg::RiseGain) + 49'd32768;
    rval  = 33'(rprod >> 16);
    rsat  = rval[32] ? 32'hFFFF_FFFF : rval[31:0];
  end

  // smoothing, two products accumulated in S_MUL
  logic        mstep_q;
  logic [48:0] sm_prod;
  always_comb begin
    if (!mstep_q) sm_prod = 49'(alpha_q) * 49'(noise_q);
    else sm_prod = 49'(17'h10000 - alpha_q) * 49'(pow_q);
  end
  logic [33:0] sm_res;
  assign sm_res = 34'(acc_q >> 16);

  logic [31:0] mnew;
  always_comb begin
    mnew = (minv_q == '0) ? noise_q : minv_q;
    if (pow_q < mnew) mnew = pow_q;
    if (mnew == '0) mnew = 32'd1;
  end

  assign div_den   = mode_q ? mnew : noise_q;
  assign div_start = (state_q == S_DEC) && !bad_q && !warm_q;

  snft_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(pow_q), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    state_d = state_q;
    n_we = 1'b0; m_we = 1'b0;
    wa = addr_q; ra = addr_q;
    n_wd = '0; m_wd = '0;
    case (state_q)
      S_CLEAR: begin
        n_we = 1'b1; m_we = 1'b1;
        if (idx_q == CW'(BINS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        ra = AW'(in_data_i.bin);
        if (acc_in) begin
          if (in_data_i.op == snft_pkg::OpTick) begin
            if (mode_q && (warmed || frames_q == FW'(WARMUP_FRAMES - 1)) &&
                phase_q == RW'(RISE_PERIOD - 1)) begin
              state_d = S_RRD;
            end
          end else state_d = S_READ;
        end
      end
      S_READ: state_d = S_DEC;
      S_DEC: begin
        if (bad_q) state_d = S_WB;
        else if (warm_q) begin
          n_we = 1'b1; n_wd = pow_q;
          m_we = mode_q; m_wd = pow_q;
          state_d = S_WB;
        end else begin
          m_we = mode_q; m_wd = mnew;
          state_d = S_DIV;
        end
      end
      S_DIV: if (div_done) state_d = S_SPCH;
      S_SPCH: state_d = S_ALPH;
      S_ALPH: state_d = S_MUL;
      S_MUL: if (mstep_q) state_d = S_WB;
      S_WB: begin
        if (!bad_q && !warm_q) begin
          n_we = 1'b1;
          n_wd = sm_res[33:32] != 2'b00 ? 32'hFFFF_FFFF : sm_res[31:0];
        end
        state_d = S_IDLE;
      end
      S_RRD: state_d = S_RWR;
      S_RWR: begin
        wa = addr_q;
        m_we = (m_rd_q != '0);
        m_wd = rsat;
        ra = AW'(idx_q);
        state_d = (idx_q == CW'(BINS)) ? S_IDLE : S_RWR;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_CLEAR) wa = idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) noise_mem[wa] <= n_wd;
    if (m_we) min_mem[wa] <= m_wd;
    n_rd_q <= noise_mem[ra];
    m_rd_q <= min_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      mode_q   <= 1'b0;
      frames_q <= '0;
      phase_q  <= '0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
      mstep_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (state_q == S_WB) ov_q <= 1'b1;
      if (state_q == S_CLEAR) idx_q <= idx_q + CW'(1);
      if (acc_in && in_data_i.op == snft_pkg::OpTick) begin
        if (!warmed) frames_q <= frames_q + FW'(1);
        phase_q <= (phase_q == RW'(RISE_PERIOD - 1)) ? '0 : phase_q + RW'(1);
        idx_q <= '0;
      end
      if (state_q == S_RRD || state_q == S_RWR) idx_q <= idx_q + CW'(1);
      if (state_q == S_MUL) mstep_q <= !mstep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pow_q  <= in_data_i.power;
      addr_q <= in_data_i.op == snft_pkg::OpTick ? '0 : AW'(in_data_i.bin);
      bad_q  <= 32'(in_data_i.bin) >= 32'(BINS);
    end
    // the sweep writes one entry behind the read
    if (state_q == S_RWR) addr_q <= AW'(idx_q);
    if (state_q == S_READ) begin
      warm_q <= !warmed || (n_rd_q == '0);
      noise_q <= n_rd_q;
      minv_q  <= m_rd_q;
    end
    if (state_q == S_DEC) spch_q <= '0;
    if (div_done) ratio_q <= div_q;
    if (state_q == S_SPCH) spch_q <= spch_c;
    if (state_q == S_ALPH) begin
      alpha_q <= alpha_c;
      acc_q   <= 50'd32768;
    end
    if (state_q == S_MUL) acc_q <= acc_q + 50'(sm_prod);
    if (state_q == S_WB) begin
      if (bad_q) out_q <= '0;
      else if (warm_q) out_q <= '{noise: pow_q, presence: 16'd0};
      else out_q <= '{noise: n_wd, presence: spch_q};
    end
  end
endmodule

// File: src/snft_checker.sv
// Port-level checker for the noise floor tracker, bound to the top level.
// Depends on snft_pkg and assert_macros.svh.
`include "assert_macros.svh"
module snft_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input snft_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input snft_pkg::rsp_t out_data_o
);
  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  `ASSERT_IMPL(spch_max_a, clk_i, rst_ni, out_valid_o,
    out_data_o.presence <= snft_pkg::SpeechOne)
  `ASSERT_IMPL(busy_out_a, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_NEXT(one_req_a, clk_i, rst_ni,
    in_valid_i && !in_stall_o && in_data_i.op == snft_pkg::OpUpdate, in_stall_o)
endmodule

bind spectral_noise_floor_tracker snft_checker u_snft_checker (.*);

// File: tb/spectral_noise_floor_tracker_test.sv
// Self-checking testbench for the spectral noise floor tracker.
// Depends on snft_pkg and spectral_noise_floor_tracker; a class predicts results.
module spectral_noise_floor_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModePosterior = 1'b0;
  localparam logic ModeMinimum   = 1'b1;
  localparam int   NumBins       = 256;
  localparam int   IdleLimit     = 5000;
  localparam int   TickSettle    = 2 * NumBins + 80;

  class noise_floor_board;
    logic [31:0] noise_est [NumBins];
    logic [31:0] floor_min [NumBins];
    int unsigned frames;
    int unsigned phase;
    logic        mode;
    snft_pkg::rsp_t expected_floor[$];
    int          errors;

    function new();
      foreach (noise_est[k]) begin
        noise_est[k] = '0;
        floor_min[k] = '0;
      end
      frames = 0;
      phase  = 0;
      mode   = ModePosterior;
      errors = 0;
    endfunction

    function logic [15:0] speech_of(logic [63:0] ratio, logic [63:0] offs,
                                    logic [63:0] slope);
      logic [63:0] s;
      if (ratio <= offs) return '0;
      s = ((ratio - offs) * slope) >> 17;
      return (s > 64'd32768) ? 16'd32768 : s[15:0];
    endfunction

    function logic [31:0] blend(logic [63:0] alpha, logic [31:0] est, logic [31:0] pwr);
      logic [63:0] acc;
      acc = (alpha * est + (64'd65536 - alpha) * pwr + 64'd32768) >> 16;
      return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    endfunction

    function void note_request(snft_pkg::req_t r);
      logic [31:0] est, m;
      logic [15:0] sp;
      logic [63:0] ratio, alpha, grown;
      snft_pkg::rsp_t res;
      if (r.op == snft_pkg::OpTick) begin
        if (frames < snft_pkg::WarmupDef) frames++;
        phase = (phase + 1) % snft_pkg::RisePeriodDef;
        if (mode == ModeMinimum && frames >= snft_pkg::WarmupDef && phase == 0) begin
          foreach (floor_min[k]) begin
            if (floor_min[k] != 0) begin
              grown = (64'(floor_min[k]) * 64'(snft_pkg::RiseGain) + 64'd32768) >> 16;
              floor_min[k] = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            end
          end
        end
        return;
      end
      est = noise_est[r.bin];
      sp  = '0;
      if (frames < snft_pkg::WarmupDef || est == 0) begin
        est = r.power;
        if (mode == ModeMinimum) floor_min[r.bin] = r.power;
      end else if (mode == ModeMinimum) begin
        m = floor_min[r.bin];
        if (m == 0) m = est;
        if (r.power < m) m = r.power;
        if (m < 1) m = 1;
        floor_min[r.bin] = m;
        ratio = (64'(r.power) << 16) / 64'(m);
        sp = speech_of(ratio, 64'(snft_pkg::MinOffset), 64'(snft_pkg::MinSlope));
        alpha = 64'(snft_pkg::AlphaBase) +
                ((64'(snft_pkg::AlphaGain) * 64'(sp) + 64'd16384) >> 15);
        est = blend(alpha, est, r.power);
      end else begin
        ratio = (64'(r.power) << 16) / 64'(est);
        sp = speech_of(ratio, 64'(snft_pkg::PostOffset), 64'(snft_pkg::PostSlope));
        alpha = (sp >= snft_pkg::PostThresh) ? 64'(snft_pkg::AlphaHigh)
                                             : 64'(snft_pkg::AlphaLow);
        est = blend(alpha, est, r.power);
      end
      noise_est[r.bin] = est;
      res.noise = est;
      res.presence = sp;
      expected_floor.push_back(res);
    endfunction

    function void check_response(snft_pkg::rsp_t got);
      snft_pkg::rsp_t want;
      if (expected_floor.size() == 0) begin
        $error("unexpected result noise=%h presence=%h", got.noise, got.presence);
        errors++;
        return;
      end
      want = expected_floor.pop_front();
      if (got.noise !== want.noise) begin
        $error("noise: expected %h, actual %h", want.noise, got.noise);
        errors++;
      end
      if (got.presence !== want.presence) begin
        $error("presence: expected %h, actual %h", want.presence, got.presence);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  snft_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  snft_pkg::rsp_t out_data_o;

  logic calm = 1'b0;
  logic rx_hold = 1'b0;
  int   idle_cycles = 0;
  noise_floor_board board = new();

  always #5 clk_i = ~clk_i;

  spectral_noise_floor_tracker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always @(negedge clk_i) begin
    out_stall_i <= rx_hold || (!calm && $urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_response(out_data_o);
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("spectral_noise_floor_tracker_test: errors");
        $finish;
      end
    end
  end

  task automatic send_request(snft_pkg::req_t r);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_update(logic [7:0] b, logic [31:0] p);
    snft_pkg::req_t r;
    r.op = snft_pkg::OpUpdate;
    r.bin = b;
    r.power = p;
    send_request(r);
  endtask

  task automatic send_tick();
    snft_pkg::req_t r;
    r.op = snft_pkg::OpTick;
    r.bin = 8'($urandom);
    r.power = $urandom;
    send_request(r);
  endtask

  // Hold the request line low until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.expected_floor.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(logic m);
    drain();
    repeat (TickSettle) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    board.mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_power(logic [7:0] b);
    logic [63:0] scaled;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 22) return $urandom;
    if (sel < 30) return 32'($urandom_range(1, 4));
    scaled = 64'(board.noise_est[b]) * $urandom_range(30, 500) / 100;
    if (scaled == 0) return $urandom_range(1, 32'h0010_0000);
    return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
  endfunction

  task automatic random_run(int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 60);
      if (i == count / 2) drain();
      if ($urandom_range(0, 99) < 12) begin
        send_tick();
      end else begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        send_update(b, pick_power(b));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(ModePosterior);
    // Warm-up updates at the field extremes, then the zero-estimate path.
    send_update(8'd0, 32'h0000_0000);
    send_update(8'd255, 32'hFFFF_FFFF);
    for (int i = 0; i < 20; i++) send_tick();
    send_update(8'd255, 32'h0000_0000);
    send_update(8'd0, 32'h0000_1000);
    send_update(8'd0, 32'h7FFF_FFFF);
    send_update(8'd1, 32'h0001_0000);

    // Stall the result side for a long stretch while requests keep coming.
    fork
      begin
        repeat (40) @(posedge clk_i);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    random_run(400);

    write_mode(ModeMinimum);
    random_run(450);
    write_mode(ModePosterior);
    random_run(200);
    write_mode(ModeMinimum);
    random_run(250);

    drain();
    repeat (TickSettle) @(negedge clk_i);
    if (board.expected_floor.size() != 0) begin
      $error("%0d results never arrived", board.expected_floor.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("spectral_noise_floor_tracker_test: clean");
    end else begin
      $display("spectral_noise_floor_tracker_test: errors");
    end
    $finish;
  end
endmodule
